// ===== hdl/lps_pkg.sv =====
// Shared widths, reset constants and interface structs for the linear prime sieve.
// No dependencies; every other file in hdl/ imports this package.
package lps_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_MAX_N       = 65536;
    localparam int DEF_PRIME_SLOTS = 8192;

    // Fixed field widths of the transactions and of the limit register.
    localparam int VAL_W   = 17;
    localparam int PRIME_W = 16;
    localparam int TOTAL_W = 13;
    localparam int LIMIT_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'hFFFF;
    localparam logic [VAL_W-1:0]   FIRST_CAND = 17'd2;

    // One result transaction.
    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic               is_prime;
        logic [TOTAL_W-1:0] prime_total;
        logic               done_res;
    } lps_res_t;

    // Status of the serial remainder unit.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } lps_div_st_t;

endpackage

// ===== hdl/linear_prime_sieve.sv =====
// Top level of the linear prime sieve: control sequencer, bitmap and prime-list memories.
// Depends on lps_pkg, lps_div and lps_out_reg.
//
// Usage. The input channel (in_valid, in_stall, restart) carries one transaction
// per step: restart = 1 clears the composite bitmap and the prime count and sets
// the candidate back to 2; restart = 0 examines the next candidate. Each input
// transaction yields exactly one result transaction on (out_valid, out_stall)
// with value, is_prime, prime_total and done_res. The limit register is written
// through the cfg_valid / cfg_ready / cfg_data channel; the user must write it
// only while the block is idle, which the block itself does not enforce. One
// item is worked on at a time. An advance step walks the prime list: each visited
// prime costs a list read, a multiply and a compare, and each mark made runs the
// serial remainder unit. A step past the limit only emits its result. A restart
// sweeps the bitmap from address 0 up to the highest address marked since the last
// sweep, one entry per cycle, then emits its result. After reset the whole bitmap
// (MAX_N entries) is swept before the first input transaction is taken;
// configuration writes are taken during the sweep. A finished result waits in the
// output register while the receiver stalls, and the next input transaction is
// already accepted meanwhile.
module linear_prime_sieve
    import lps_pkg::*;
#(
    parameter int MAX_N       = DEF_MAX_N,
    parameter int PRIME_SLOTS = DEF_PRIME_SLOTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Input transactions.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    // Result transactions.
    output logic               out_valid,
    input  logic               out_stall,
    output logic [VAL_W-1:0]   value,
    output logic               is_prime,
    output logic [TOTAL_W-1:0] prime_total,
    output logic               done_res,
    // Limit register write port.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int AW       = $clog2(MAX_N);
    localparam int LW       = $clog2(PRIME_SLOTS);
    localparam int CW       = $clog2(PRIME_SLOTS + 1);
    localparam int PROD_W   = VAL_W + PRIME_W;
    localparam int LIM_TOPI = (MAX_N - 1 < 65535) ? MAX_N - 1 : 65535;
    localparam logic [LIMIT_W-1:0] LIM_TOP  = LIMIT_W'(LIM_TOPI);
    localparam logic [AW-1:0]      MAP_LAST = AW'(MAX_N - 1);
    localparam logic [CW-1:0]      SLOTS_C  = CW'(PRIME_SLOTS);

    // Sequencer state codes.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_LREAD = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    // The reported count saturates at the width of prime_total.
    function automatic logic [TOTAL_W-1:0] sat_total(input logic [CW-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return (wide < 32'((1 << TOTAL_W) - 1)) ? TOTAL_W'(wide)
                                                : TOTAL_W'((1 << TOTAL_W) - 1);
    endfunction

    // Control and working registers.
    logic [2:0]         state_reg,     state_next;
    logic [VAL_W-1:0]   cand_reg,      cand_next;
    logic [CW-1:0]      count_reg,     count_next;
    logic [CW-1:0]      j_reg,         j_next;
    logic [AW-1:0]      clr_addr_reg,  clr_addr_next;
    logic [AW-1:0]      clr_end_reg,   clr_end_next;
    logic [AW-1:0]      hiwater_reg,   hiwater_next;
    logic               pend_reg,      pend_next;
    logic [LIMIT_W-1:0] limit_reg,     limit_next;
    logic [VAL_W-1:0]   res_value_reg, res_value_next;
    logic               res_prime_reg, res_prime_next;
    logic               res_done_reg,  res_done_next;
    logic [PROD_W-1:0]  prod_reg,      prod_next;
    logic [PRIME_W-1:0] p_reg,         p_next;

    // Memories: one mark bit per value, and the list of primes found so far.
    logic               map_mem [MAX_N];
    logic [PRIME_W-1:0] list_mem [PRIME_SLOTS];
    logic               map_rdata_reg;
    logic [PRIME_W-1:0] list_rdata_reg;

    logic               map_we;
    logic [AW-1:0]      map_waddr;
    logic               map_wdata;
    logic [AW-1:0]      map_raddr;
    logic               list_we;
    logic [LW-1:0]      list_waddr;
    logic [LW-1:0]      list_raddr;

    logic [LIMIT_W-1:0] lim_eff;
    logic               in_accept;
    logic               over_limit;
    logic               div_start;
    lps_div_st_t        div_st;
    logic               push;
    logic               can_take;
    lps_res_t           res_in;
    lps_res_t           res_out;

    // The bitmap is never indexed beyond its depth.
    assign lim_eff    = (limit_reg < LIM_TOP) ? limit_reg : LIM_TOP;
    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign over_limit = (prod_reg > PROD_W'(lim_eff));

    // The bitmap is read at the current candidate; the read issued at acceptance
    // is consumed in S_CHECK. Marks always land above the candidate being checked
    // and a step finishes all its writes before the next read, so no entry is
    // read and written in overlapping cycles.
    assign map_raddr  = AW'(cand_reg);
    assign list_raddr = j_reg[LW-1:0];
    assign list_waddr = count_reg[LW-1:0];

    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = AW'(prod_reg);
        map_wdata = 1'b1;
        list_we   = 1'b0;
        div_start = 1'b0;
        push      = 1'b0;

        state_next     = state_reg;
        cand_next      = cand_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        clr_addr_next  = clr_addr_reg;
        clr_end_next   = clr_end_reg;
        hiwater_next   = hiwater_reg;
        pend_next      = pend_reg;
        limit_next     = limit_reg;
        res_value_next = res_value_reg;
        res_prime_next = res_prime_reg;
        res_done_next  = res_done_reg;
        prod_next      = prod_reg;
        p_next         = p_reg;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the bitmap one entry per cycle.
                map_we    = 1'b1;
                map_waddr = clr_addr_reg;
                map_wdata = 1'b0;
                if (clr_addr_reg == clr_end_reg)
                begin
                    hiwater_next = '0;
                    pend_next    = 1'b0;
                    state_next   = pend_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (restart)
                    begin
                        res_value_next = '0;
                        res_prime_next = 1'b0;
                        res_done_next  = 1'b0;
                        count_next     = '0;
                        cand_next      = FIRST_CAND;
                        clr_addr_next  = '0;
                        clr_end_next   = hiwater_reg;
                        pend_next      = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    else if (cand_reg > VAL_W'(lim_eff))
                    begin
                        // Past the limit: report done, leave the candidate alone.
                        res_value_next = cand_reg;
                        res_prime_next = 1'b0;
                        res_done_next  = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        res_value_next = cand_reg;
                        res_done_next  = 1'b0;
                        cand_next      = cand_reg + VAL_W'(1);
                        state_next     = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                res_prime_next = !map_rdata_reg;
                if (!map_rdata_reg && (count_reg < SLOTS_C))
                begin
                    list_we    = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                j_next     = '0;
                state_next = S_LREAD;
            end

            S_LREAD:
            begin
                // The list read at index j is registered on this edge.
                state_next = (j_reg < count_reg) ? S_MUL : S_EMIT;
            end

            S_MUL:
            begin
                prod_next  = PROD_W'(res_value_reg) * PROD_W'(list_rdata_reg);
                p_next     = list_rdata_reg;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (over_limit)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    map_we    = 1'b1;
                    div_start = 1'b1;
                    if (AW'(prod_reg) > hiwater_reg)
                    begin
                        hiwater_next = AW'(prod_reg);
                    end
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // The walk ends at the first listed prime that divides the candidate.
                if (div_st.done)
                begin
                    if (div_st.rem_zero)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = S_LREAD;
                    end
                end
            end

            S_EMIT:
            begin
                if (can_take)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cand_reg      <= FIRST_CAND;
            count_reg     <= '0;
            j_reg         <= '0;
            clr_addr_reg  <= '0;
            clr_end_reg   <= MAP_LAST;
            hiwater_reg   <= '0;
            pend_reg      <= 1'b0;
            limit_reg     <= LIMIT_RST;
            res_value_reg <= '0;
            res_prime_reg <= 1'b0;
            res_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cand_reg      <= cand_next;
            count_reg     <= count_next;
            j_reg         <= j_next;
            clr_addr_reg  <= clr_addr_next;
            clr_end_reg   <= clr_end_next;
            hiwater_reg   <= hiwater_next;
            pend_reg      <= pend_next;
            limit_reg     <= limit_next;
            res_value_reg <= res_value_next;
            res_prime_reg <= res_prime_next;
            res_done_reg  <= res_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        p_reg    <= p_next;
    end

    // Composite bitmap: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_raddr];
    end

    // Prime list: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= PRIME_W'(res_value_reg);
        end
        list_rdata_reg <= list_mem[list_raddr];
    end

    lps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (res_value_reg),
        .divisor  (p_reg),
        .status   (div_st)
    );

    assign res_in.value       = res_value_reg;
    assign res_in.is_prime    = res_prime_reg;
    assign res_in.prime_total = sat_total(count_reg);
    assign res_in.done_res    = res_done_reg;

    lps_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res_in    (res_in),
        .out_stall (out_stall),
        .can_take  (can_take),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign value       = res_out.value;
    assign is_prime    = res_out.is_prime;
    assign prime_total = res_out.prime_total;
    assign done_res    = res_out.done_res;

endmodule

// ===== hdl/lps_div.sv =====
// Serial restoring remainder unit: tells whether a divisor divides a dividend.
// Depends on lps_pkg for widths and the status struct.
module lps_div
    import lps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VAL_W-1:0]   dividend,
    input  logic [PRIME_W-1:0] divisor,
    output lps_div_st_t        status
);

    localparam int CNT_W = $clog2(VAL_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VAL_W-1:0] dvd_reg;
    logic [PRIME_W-1:0] dsr_reg;
    logic [PRIME_W-1:0] rem_reg;

    logic [PRIME_W:0]   shifted;
    logic [PRIME_W:0]   diff;
    logic [PRIME_W-1:0] rem_next;

    // One quotient bit per cycle; the partial remainder always stays below the divisor.
    assign shifted  = {rem_reg, dvd_reg[VAL_W-1]};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign rem_next = (shifted >= {1'b0, dsr_reg}) ? diff[PRIME_W-1:0]
                                                   : shifted[PRIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VAL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[VAL_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

// ===== hdl/lps_out_reg.sv =====
// Output holding register for result transactions, decoupling the sieve from the receiver.
// Depends on lps_pkg for the result struct.
module lps_out_reg
    import lps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lps_res_t res_in,
    input  logic     out_stall,
    output logic     can_take,
    output logic     out_valid,
    output lps_res_t res_out
);

    logic     valid_reg;
    lps_res_t data_reg;

    // A new result may enter when the slot is empty or is being emptied this cycle.
    assign can_take = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

// ===== tb/tb_linear_prime_sieve.sv =====
// Self-checking testbench for the linear prime sieve: a scoreboard class that tracks the
// sieve state and predicts each result, plus tasks that drive the input channel and the limit port.
// Depends on lps_pkg and on the linear_prime_sieve RTL.
module tb_linear_prime_sieve;
    import lps_pkg::*;

    // Tracks the sieve state and keeps the results still expected from the block.
    class sieve_tracker;
        bit                 composite [DEF_MAX_N];
        logic [PRIME_W-1:0] primes [DEF_PRIME_SLOTS];
        int unsigned        found;
        logic [VAL_W-1:0]   cand;
        logic [LIMIT_W-1:0] lim;
        lps_res_t           pending_results [$];
        int                 errors;

        function new();
            foreach (composite[i]) composite[i] = 1'b0;
            found  = 0;
            cand   = FIRST_CAND;
            lim    = LIMIT_RST;
            errors = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            lim = v;
        endfunction

        function int unsigned top_value();
            int unsigned cap;
            cap = DEF_MAX_N - 1;
            return (lim < cap) ? lim : cap;
        endfunction

        function bit past_limit();
            return cand > top_value();
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Works out the result of one accepted input transaction.
        function void take_step(bit rs);
            lps_res_t        r;
            int unsigned     eff;
            int unsigned     c;
            int unsigned     p;
            longint unsigned k;
            r   = '0;
            eff = top_value();
            c   = cand;
            if (rs) begin
                foreach (composite[i]) composite[i] = 1'b0;
                found = 0;
                cand  = FIRST_CAND;
            end else begin
                r.value = c[VAL_W-1:0];
                if (c > eff) begin
                    r.done_res = 1'b1;
                end else begin
                    if (!composite[c]) begin
                        r.is_prime = 1'b1;
                        if (found < DEF_PRIME_SLOTS) begin
                            primes[found] = c[PRIME_W-1:0];
                            found++;
                        end
                    end
                    for (int j = 0; j < found && j < DEF_PRIME_SLOTS; j++) begin
                        p = primes[j];
                        if (p == 0) break;
                        k = longint'(c) * longint'(p);
                        if (k > eff) break;
                        composite[k] = 1'b1;
                        if (c % p == 0) break;
                    end
                    cand = VAL_W'(c + 1);
                end
                r.prime_total = (found < 8191) ? TOTAL_W'(found) : TOTAL_W'(8191);
            end
            pending_results.push_back(r);
        endfunction

        function void report(string name, logic [VAL_W-1:0] exp, logic [VAL_W-1:0] got);
            if (got !== exp) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp, got);
                errors++;
            end
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void match_result(logic [VAL_W-1:0] v, logic ip, logic [TOTAL_W-1:0] tot,
                                   logic dn);
            lps_res_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got value %0d", $time, v);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            report("value", e.value, v);
            report("is_prime", e.is_prime, ip);
            report("prime_total", e.prime_total, tot);
            report("done_res", e.done_res, dn);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               restart = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [VAL_W-1:0]   value;
    logic               is_prime;
    logic [TOTAL_W-1:0] prime_total;
    logic               done_res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;

    sieve_tracker tracker = new();

    // Sender burst bookkeeping and receiver stall pattern state.
    int burst_left = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_tick = 0;

    linear_prime_sieve i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .is_prime    (is_prime),
        .prime_total (prime_total),
        .done_res    (done_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver switches between stall patterns every so often: no stalls at all,
    // light random stalls, heavy random stalls, and a fixed periodic pattern. This
    // lets stalls fall on every phase of the block's work, including the long sweeps.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 300);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    // All inputs and outputs change only at rising edges, so values seen at the falling
    // edge are the ones the next rising edge acts on. A result transaction is therefore
    // checked at the falling edge just before the edge that accepts it.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_result(value, is_prime, prime_total, done_res);
    end

    // Sends one input transaction. Before it, the sender may close its current burst and
    // sit idle for a while; a gap of zero keeps in_valid high across bursts, which gives
    // stretches of back-to-back traffic. The task returns at the accepting edge, so the
    // caller's next drive lands in a later time step than this one.
    task automatic send_item(input bit rs);
        int gap;
        bit taken;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        restart  <= rs;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        tracker.take_step(rs);
    endtask

    // Lowers the input channel and waits until every expected result has arrived, then waits
    // longer so that the output register has certainly drained.
    task automatic wait_empty();
        in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.outstanding() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes the limit register. The extra edge at the end keeps a following write from
    // lowering and raising cfg_valid in one time step.
    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        tracker.set_limit(v);
        @(posedge clk);
    endtask

    // One random phase: a new limit, usually a restart, then a run of advance steps.
    // Restarts are rare while the candidate is still inside the limit, so most steps do
    // real sieving; once the sieve has run past the limit, a restart comes soon.
    task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n_items);
        bit rs;
        wait_empty();
        write_limit(lim);
        if ($urandom_range(0, 3) != 0)
            send_item(1'b1);
        repeat (n_items)
        begin
            if (tracker.past_limit())
                rs = ($urandom_range(0, 3) == 0);
            else
                rs = ($urandom_range(0, 59) == 0);
            send_item(rs);
        end
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest limit that admits a prime: 2 is prime, then 3 is already past the limit and the
        // candidate stays put while done is reported.
        write_limit(16'd2);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        // A limit below two: candidate 2 is past the limit right away.
        wait_empty();
        write_limit(16'd0);
        send_item(1'b0);
        send_item(1'b1);
        wait_empty();
        write_limit(16'd1);
        send_item(1'b0);
        // Raising the limit resumes the sieve from the held candidate; the first dozen
        // values mix primes and composites, then a restart clears everything.
        wait_empty();
        write_limit(16'd30);
        repeat (12) send_item(1'b0);
        send_item(1'b1);

        for (int i = 0; i < 9; i++)
        begin
            case (i)
                0:       lim = 16'hFFFF;
                1:       lim = LIMIT_W'($urandom_range(2, 50));
                2:       lim = LIMIT_W'($urandom_range(51, 400));
                3:       lim = LIMIT_W'($urandom_range(401, 3000));
                4:       lim = LIMIT_W'($urandom_range(0, 1));
                5:       lim = LIMIT_W'($urandom_range(3001, 65535));
                6:       lim = LIMIT_W'($urandom_range(2, 200));
                7:       lim = 16'd2;
                default: lim = LIMIT_W'($urandom_range(2, 65535));
            endcase
            run_phase(lim, 95);
        end

        wait_empty();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("tb_linear_prime_sieve passed");
        else
            $display("tb_linear_prime_sieve failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, including the sweep after reset.
    initial
    begin
        #60000000;
        $display("tb_linear_prime_sieve failed");
        $finish;
    end

endmodule
